>>> src/irad_pkg.sv
// ----------------------------------------------------------------------------
// irad_pkg
// Shared types and constants for the integer radical block: the command
// bundle from controller to datapath and the status bundle back.
// ----------------------------------------------------------------------------
`default_nettype none

package irad_pkg;

   // Width of the value and radical ports
   localparam int unsigned PORT_W = 32;

   // First odd trial divisor and the divisor step
   localparam int unsigned FIRST_DIV = 3;
   localparam int unsigned DIV_STEP  = 2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;       // capture a new request
      logic halve;      // shift out one factor of two
      logic d_init;     // set divisor to the first odd divisor
      logic d_next;     // advance divisor to the next odd value
      logic div_start;  // clear remainder and load the dividend
      logic div_step;   // one restoring division step
      logic take_q;     // replace value by the quotient
      logic mul_d;      // multiply accumulated radical by divisor
      logic emit;       // write final product to the response register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic n_zero;     // remaining value is zero
      logic n_even;     // remaining value is even
      logic div_last;   // division is on its last step
      logic bound_fail; // divisor exceeds quotient: divisor squared > value
      logic rem_zero;   // division left no remainder
   } status_type;

endpackage : irad_pkg

`default_nettype wire

>>> src/irad_dp.sv
// ----------------------------------------------------------------------------
// irad_dp
// Datapath: value, divisor and radical registers, a one-bit-per-cycle
// restoring divider, one shared multiplier and the response payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module irad_dp
   import irad_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  wire logic              clock,
   input  wire logic [PORT_W-1:0] req_value_in,
   input  wire cmd_type           cmd,
   output status_type             st,
   output logic      [PORT_W-1:0] rsp_radical,
   output logic                   rsp_input_invalid
);

   // Arithmetic width: the low bits of the value port that take part
   localparam int unsigned NW = (VALUE_WIDTH < PORT_W) ? VALUE_WIDTH : PORT_W;
   localparam int unsigned CW = $clog2(NW);
   localparam int unsigned PW = 2 * NW;

   logic [NW-1:0] n_ff,   n_in;
   logic [NW-1:0] acc_ff, acc_in;
   logic [NW-1:0] d_ff,   d_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          invalid_ff, invalid_in;
   logic [PORT_W-1:0] rad_ff, rad_in;
   logic          rsp_inv_ff, rsp_inv_in;

   logic [NW:0]   shifted;
   logic [NW:0]   diff;
   logic [NW-1:0] mul_b;
   logic [PW-1:0] prod;
   logic [NW-1:0] masked;

   assign masked = req_value_in[NW-1:0];

   // Restoring division step: bring down next dividend bit, try subtract
   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign diff    = shifted - {1'b0, d_ff};

   // Shared multiplier: divisor while accumulating, remaining value at the end
   assign mul_b = cmd.emit ? n_ff : d_ff;
   assign prod  = PW'(acc_ff) * PW'(mul_b);

   // Next-state logic for all datapath registers
   always_comb begin
      n_in       = n_ff;
      acc_in     = acc_ff;
      d_in       = d_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      invalid_in = invalid_ff;
      rad_in     = rad_ff;
      rsp_inv_in = rsp_inv_ff;

      if (cmd.load) begin
         n_in       = masked;
         acc_in     = NW'(1);
         invalid_in = (masked == '0);
      end
      if (cmd.halve) begin
         n_in   = n_ff >> 1;
         acc_in = NW'(2);
      end
      if (cmd.take_q) begin
         n_in = quo_ff;
      end
      if (cmd.d_init) begin
         d_in = NW'(FIRST_DIV);
      end
      if (cmd.d_next) begin
         d_in = d_ff + NW'(DIV_STEP);
      end
      if (cmd.mul_d) begin
         acc_in = prod[NW-1:0];
      end

      // Start a division on the value as it will stand next cycle
      if (cmd.div_start) begin
         quo_in = cmd.take_q ? quo_ff : n_ff;
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff + CW'(1);
         if (!diff[NW]) begin
            rem_in = diff[NW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[NW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
      end

      // Final product goes straight into the response register
      if (cmd.emit) begin
         rad_in     = PORT_W'(prod[NW-1:0]);
         rsp_inv_in = invalid_ff;
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      acc_ff     <= acc_in;
      d_ff       <= d_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      invalid_ff <= invalid_in;
      rad_ff     <= rad_in;
      rsp_inv_ff <= rsp_inv_in;
   end

   // Status back to the controller
   assign st.n_zero     = (n_ff == '0);
   assign st.n_even     = ~n_ff[0];
   assign st.div_last   = (cnt_ff == CW'(NW - 1));
   assign st.bound_fail = (d_ff > quo_ff);
   assign st.rem_zero   = (rem_ff == '0);

   assign rsp_radical       = rad_ff;
   assign rsp_input_invalid = rsp_inv_ff;

endmodule : irad_dp

`default_nettype wire

>>> src/irad_ctrl.sv
// ----------------------------------------------------------------------------
// irad_ctrl
// Controller: sequences factor-of-two stripping, odd trial division with the
// bound test, dividing out each factor, and the final multiply; owns the
// request and response handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module irad_ctrl
   import irad_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output cmd_type         cmd,
   input  wire status_type st
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_STRIP  = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_MULD   = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       mode_ff, mode_in;      // high while dividing out a found factor
   logic       rsp_valid_ff, rsp_valid_in;

   // Sequence the datapath
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_STRIP;
            end
         end
         S_STRIP: begin
            if (st.n_zero) begin
               state_in = S_OUT;
            end else if (st.n_even) begin
               cmd.halve = 1'b1;
            end else begin
               cmd.d_init    = 1'b1;
               cmd.div_start = 1'b1;
               mode_in       = 1'b0;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!mode_ff && st.bound_fail) begin
               // no divisor left below the square root: remaining value is 1 or prime
               state_in = S_OUT;
            end else if (st.rem_zero) begin
               cmd.take_q    = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = mode_ff ? S_DIV : S_MULD;
            end else begin
               cmd.d_next    = 1'b1;
               cmd.div_start = 1'b1;
               mode_in       = 1'b0;
               state_in      = S_DIV;
            end
         end
         S_MULD: begin
            // count a new prime factor once, then divide it out
            cmd.mul_d = 1'b1;
            mode_in   = 1'b1;
            state_in  = S_DIV;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Never overwrite a response that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit && rsp_valid_ff && rsp_stall))
      else $error("response overwritten while stalled");

   // A factor is only counted right after it was found to divide
   a_mul_after_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_d |-> $past(cmd.take_q))
      else $error("multiply without a preceding exact division");

   // The quotient is only taken when the division was exact
   a_take_exact: assert property (@(posedge clock) disable iff (reset)
      cmd.take_q |-> st.rem_zero)
      else $error("quotient taken with nonzero remainder");

   // The last division step always leads to a decision
   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && st.div_last) |=> (state_ff == S_DECIDE))
      else $error("division did not end in decision");

endmodule : irad_ctrl

`default_nettype wire

>>> src/integer_radical_top.sv
// ----------------------------------------------------------------------------
// integer_radical_top
// Radical of an unsigned value by trial division, one request at a time.
// ----------------------------------------------------------------------------
// Steps: load, a halving per trailing zero, an NW-bit division per trial
//   divisor or factor, a multiply per odd prime; NW = min(VALUE_WIDTH, 32).
// Throughput: one request at a time; the one-bit-per-cycle divider sets it.
// A finished response waits in its output register; the next request is
//   taken while it waits. Reset is synchronous and clears control state only.
`default_nettype none

module integer_radical_top
   import irad_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [PORT_W-1:0] req_value_in,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [PORT_W-1:0] rsp_radical,
   output logic                   rsp_input_invalid
);

   cmd_type    cmd;
   status_type st;

   irad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .st        (st)
   );

   irad_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock             (clock),
      .req_value_in      (req_value_in),
      .cmd               (cmd),
      .st                (st),
      .rsp_radical       (rsp_radical),
      .rsp_input_invalid (rsp_input_invalid)
   );

endmodule : integer_radical_top

`default_nettype wire
